// ----- src/w3ss_pkg.sv -----
// Shared types and constants of the weighted 3x3 smoothing stencil.
`timescale 1ns / 1ps
`default_nettype none

package w3ss_pkg;

    localparam int PIXEL_W     = 16;
    localparam int CFG_W       = 13;
    localparam int ROW_W       = 12;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_DIM     = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_W-1:0] DIM_RESET = 13'd4096;

    localparam int DIVISOR     = 50;
    localparam int SUM_W       = PIXEL_W + 6;
    localparam int MAG_W       = PIXEL_W + 5;
    localparam int RECIP_SHIFT = MAG_W + 6;
    localparam int RECIP_W     = RECIP_SHIFT - 5;
    localparam int PROD_W      = MAG_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

    localparam logic signed [SUM_W-1:0] CENTRE_WEIGHT = 22'sd42;

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [PIXEL_W-1:0] pixel_in;
        logic                      drain;
    } in_word_t;

    typedef struct packed {
        logic signed [PIXEL_W-1:0] smoothed;
        logic                      end_of_row;
        logic                      end_of_frame;
    } out_word_t;

    typedef struct packed {
        logic signed [PIXEL_W-1:0] pixel;
        logic                      store;
        logic                      top_edge;
        logic                      emit;
        logic                      left_edge;
        logic                      end_of_row;
        logic                      end_of_frame;
    } cmd_t;

endpackage

`default_nettype wire

// ----- src/w3ss_front.sv -----
// Front end: accepts words, tracks raster positions and issues stencil commands.
`timescale 1ns / 1ps
`default_nettype none

module w3ss_front #(
    parameter int  MAX_WIDTH = 4096,
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire w3ss_pkg::in_word_t            in_word,
    input  wire logic                          cfg_wr_en,
    input  wire w3ss_pkg::cfg_index_t          cfg_index,
    input  wire logic [w3ss_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                          q_ready,
    output logic                               push,
    output w3ss_pkg::cmd_t                     cmd,
    output logic [COL_W-1:0]                   cmd_col
);
    import w3ss_pkg::*;

    localparam int EXT_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [COL_W-1:0] in_col_reg;
    logic [COL_W-1:0] in_col_next;
    logic [ROW_W-1:0] in_row_reg;
    logic [ROW_W-1:0] in_row_next;
    logic             in_done_reg;
    logic             in_done_next;
    logic [COL_W-1:0] out_col_reg;
    logic [COL_W-1:0] out_col_next;
    logic [ROW_W-1:0] out_row_reg;
    logic [ROW_W-1:0] out_row_next;

    logic [EXT_W-1:0] width_ext;
    logic [EXT_W-1:0] width_eff;
    logic [CFG_W-1:0] height_eff;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
    logic             accept;
    logic             is_pixel;
    logic             primed;
    logic             take_col;
    logic             emit;
    logic             out_col_end;
    logic             out_row_end;

    assign width_ext = EXT_W'(width_reg);

    always_comb
    begin
        priority if (width_ext < EXT_W'(MIN_DIM))
            width_eff = EXT_W'(MIN_DIM);
        else if (width_ext > EXT_W'(MAX_WIDTH))
            width_eff = EXT_W'(MAX_WIDTH);
        else
            width_eff = width_ext;
    end

    always_comb
    begin
        priority if (height_reg < CFG_W'(MIN_DIM))
            height_eff = CFG_W'(MIN_DIM);
        else if (height_reg > CFG_W'(MAX_HEIGHT))
            height_eff = CFG_W'(MAX_HEIGHT);
        else
            height_eff = height_reg;
    end

    assign col_last = COL_W'(width_eff - EXT_W'(1));
    assign row_last = ROW_W'(height_eff - CFG_W'(1));

    assign in_ready    = q_ready;
    assign accept      = in_valid && in_ready;
    assign is_pixel    = !in_word.drain && !in_done_reg;
    assign primed      = (in_row_reg > ROW_W'(1))
                      || (in_row_reg == ROW_W'(1) && in_col_reg != '0);
    assign take_col    = accept && (is_pixel || in_done_reg);
    assign emit        = take_col && (in_done_reg || primed);
    assign out_col_end = (out_col_reg == col_last);
    assign out_row_end = (out_row_reg == row_last);

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (take_col)
        begin
            if (in_col_reg == col_last)
            begin
                in_col_next = '0;
                if (is_pixel)
                begin
                    if (in_row_reg == row_last)
                        in_done_next = 1'b1;
                    else
                        in_row_next = in_row_reg + ROW_W'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end
        if (emit)
        begin
            if (out_col_end)
            begin
                out_col_next = '0;
                if (out_row_end)
                begin
                    // frame complete: rewind every position
                    in_col_next  = '0;
                    in_row_next  = '0;
                    in_done_next = 1'b0;
                    out_row_next = '0;
                end
                else
                begin
                    out_row_next = out_row_reg + ROW_W'(1);
                end
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= DIM_RESET;
            height_reg  <= DIM_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_done_reg <= 1'b0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
            endcase
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_done_reg <= 1'b0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_done_reg <= in_done_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    assign push             = take_col;
    assign cmd_col          = in_col_reg;
    assign cmd.pixel        = in_word.pixel_in;
    assign cmd.store        = is_pixel;
    assign cmd.top_edge     = is_pixel && (in_row_reg == ROW_W'(1));
    assign cmd.emit         = emit;
    assign cmd.left_edge    = (out_col_reg == '0);
    assign cmd.end_of_row   = out_col_end;
    assign cmd.end_of_frame = out_col_end && out_row_end;

endmodule

`default_nettype wire

// ----- src/w3ss_fifo.sv -----
// Short command queue between the front end and the stencil datapath.
`timescale 1ns / 1ps
`default_nettype none

module w3ss_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   not_full,
    input  wire logic              pop,
    output logic                   pop_valid,
    output logic [DATA_W-1:0]      pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && pop_valid;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

    always_comb
    begin
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_next;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- src/w3ss_back.sv -----
// Datapath: line stores, 3x3 window, weighted sum and division by fifty.
`timescale 1ns / 1ps
`default_nettype none

module w3ss_back #(
    parameter int  MAX_WIDTH = 4096,
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire w3ss_pkg::cmd_t     cmd,
    input  wire logic [COL_W-1:0]   cmd_col,
    output logic                    cmd_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output w3ss_pkg::out_word_t     out_word
);
    import w3ss_pkg::*;

    localparam int TRIO_W = PIXEL_W + 2;
    localparam int PAIR_W = PIXEL_W + 1;

    typedef logic signed [PIXEL_W-1:0] pix_t;

    typedef struct packed {
        pix_t up;
        pix_t mid;
        pix_t low;
    } column_t;

    typedef struct packed {
        logic end_of_row;
        logic end_of_frame;
    } tag_t;

    pix_t upper_mem  [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];
    pix_t up_rd_reg;
    pix_t mid_rd_reg;

    logic             advance;
    logic             s1_fire;

    logic             s1_valid_reg;
    cmd_t             s1_cmd_reg;
    logic [COL_W-1:0] s1_col_reg;

    column_t          prev_reg;
    column_t          cur_reg;
    column_t          fresh;
    column_t          west_sel;
    column_t          east_sel;

    logic                     s2_valid_reg;
    tag_t                     s2_tag_reg;
    logic signed [TRIO_W-1:0] west_sum_reg;
    logic signed [TRIO_W-1:0] west_sum_next;
    logic signed [TRIO_W-1:0] east_sum_reg;
    logic signed [TRIO_W-1:0] east_sum_next;
    logic signed [PAIR_W-1:0] vert_sum_reg;
    logic signed [PAIR_W-1:0] vert_sum_next;
    logic signed [SUM_W-1:0]  centre_reg;
    logic signed [SUM_W-1:0]  centre_next;

    logic                     s3_valid_reg;
    tag_t                     s3_tag_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;

    logic                     s4_valid_reg;
    tag_t                     s4_tag_reg;
    logic                     s4_neg_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [MAG_W-1:0]         mag_next;
    logic signed [SUM_W-1:0]  sum_abs;

    logic                     s5_valid_reg;
    tag_t                     s5_tag_reg;
    logic                     s5_neg_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [PROD_W-1:0]        prod_next;

    logic [PIXEL_W-1:0]       quot;
    logic                     out_valid_reg;
    out_word_t                out_word_reg;
    out_word_t                out_word_next;

    assign advance = !out_valid_reg || out_ready;
    assign cmd_pop = cmd_valid && advance;
    assign s1_fire = s1_valid_reg && advance;

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_cmd_reg.store)
        begin
            upper_mem[s1_col_reg]  <= mid_rd_reg;
            middle_mem[s1_col_reg] <= s1_cmd_reg.pixel;
        end
        if (cmd_pop)
        begin
            up_rd_reg  <= upper_mem[cmd_col];
            mid_rd_reg <= middle_mem[cmd_col];
        end
    end

    always_comb
    begin
        fresh.up  = s1_cmd_reg.top_edge ? mid_rd_reg : up_rd_reg;
        fresh.mid = mid_rd_reg;
        fresh.low = s1_cmd_reg.store ? s1_cmd_reg.pixel : mid_rd_reg;
        west_sel  = s1_cmd_reg.left_edge  ? cur_reg : prev_reg;
        east_sel  = s1_cmd_reg.end_of_row ? cur_reg : fresh;
    end

    assign west_sum_next = TRIO_W'(west_sel.up) + TRIO_W'(west_sel.mid)
                         + TRIO_W'(west_sel.low);
    assign east_sum_next = TRIO_W'(east_sel.up) + TRIO_W'(east_sel.mid)
                         + TRIO_W'(east_sel.low);
    assign vert_sum_next = PAIR_W'(cur_reg.up) + PAIR_W'(cur_reg.low);
    assign centre_next   = SUM_W'(cur_reg.mid) * CENTRE_WEIGHT;

    assign sum_next = SUM_W'(west_sum_reg) + SUM_W'(east_sum_reg)
                    + SUM_W'(vert_sum_reg) + centre_reg;

    assign sum_abs  = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
    assign mag_next = sum_abs[MAG_W-1:0];

    assign prod_next = PROD_W'(mag_reg) * PROD_W'(RECIP);

    assign quot = prod_reg[RECIP_SHIFT +: PIXEL_W];

    always_comb
    begin
        out_word_next.smoothed     = s5_neg_reg ? signed'(-quot) : signed'(quot);
        out_word_next.end_of_row   = s5_tag_reg.end_of_row;
        out_word_next.end_of_frame = s5_tag_reg.end_of_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= cmd_valid;
            s2_valid_reg  <= s1_valid_reg && s1_cmd_reg.emit;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= fresh;
        end
        if (advance)
        begin
            s1_cmd_reg   <= cmd;
            s1_col_reg   <= cmd_col;
            s2_tag_reg   <= '{end_of_row:   s1_cmd_reg.end_of_row,
                              end_of_frame: s1_cmd_reg.end_of_frame};
            west_sum_reg <= west_sum_next;
            east_sum_reg <= east_sum_next;
            vert_sum_reg <= vert_sum_next;
            centre_reg   <= centre_next;
            s3_tag_reg   <= s2_tag_reg;
            sum_reg      <= sum_next;
            s4_tag_reg   <= s3_tag_reg;
            s4_neg_reg   <= sum_reg[SUM_W-1];
            mag_reg      <= mag_next;
            s5_tag_reg   <= s4_tag_reg;
            s5_neg_reg   <= s4_neg_reg;
            prod_reg     <= prod_next;
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

// ----- src/weighted_3x3_smoothing_stencil.sv -----
// Top level of the weighted 3x3 smoothing stencil.
// Input channel (in_valid/in_ready/in_word): one pixel word per cycle in raster
// order while in_ready is high, or a drain word. The result for raster
// position k is released by pixel k + W + 1 of the frame (W = image_width);
// after the last pixel, W + 1 drain words push out the rest of the frame,
// one each. Output channel (out_valid/out_ready/out_word): one result word per
// releasing input word, flagged at row and frame end.
// Throughput: one word per cycle on both sides unless the receiver stalls; each
// word costs one read and at most one write of the two line stores, which sets
// the rate. A releasing word passes the queue slot, line store read, column
// sums, total sum, absolute value, reciprocal multiply and output register.
// Configuration (cfg_wr_en/cfg_index/cfg_data) restarts the frame; the user
// must write it only when idle, the block does not enforce it. Reset restores
// both sizes to 4096 and empties queue and pipeline; line stores need no
// clearing, no value read before its write is used. A stalled receiver
// freezes the back pipeline; the four-word queue then fills and in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module weighted_3x3_smoothing_stencil #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire w3ss_pkg::in_word_t         in_word,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output w3ss_pkg::out_word_t             out_word,
    input  wire logic                       cfg_wr_en,
    input  wire w3ss_pkg::cfg_index_t       cfg_index,
    input  wire logic [w3ss_pkg::CFG_W-1:0] cfg_data
);
    import w3ss_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int CMD_W   = $bits(cmd_t);
    localparam int QDATA_W = CMD_W + COL_W;

    logic               q_ready;
    logic               push;
    cmd_t               front_cmd;
    logic [COL_W-1:0]   front_col;
    logic               pop;
    logic               q_valid;
    logic [QDATA_W-1:0] q_data;
    cmd_t               back_cmd;
    logic [COL_W-1:0]   back_col;

    w3ss_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_ready   (q_ready),
        .push      (push),
        .cmd       (front_cmd),
        .cmd_col   (front_col)
    );

    w3ss_fifo #(
        .DATA_W (QDATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({front_cmd, front_col}),
        .not_full  (q_ready),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    assign back_cmd = cmd_t'(q_data[QDATA_W-1 -: CMD_W]);
    assign back_col = q_data[COL_W-1:0];

    w3ss_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (back_cmd),
        .cmd_col   (back_col),
        .cmd_pop   (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

// ----- src/w3ss_checker.sv -----
// Port-level checks of the smoothing stencil, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module w3ss_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire w3ss_pkg::out_word_t out_word
);
    import w3ss_pkg::*;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word dropped or changed while stalled");

    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.end_of_frame |-> out_word.end_of_row)
        else $error("frame end flagged away from a row end");

    a_ready_after_reset: assert property (@(posedge clk)
        !rst_n |=> in_ready)
        else $error("input not ready straight after reset");

    a_quiet_after_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result word straight after reset");

endmodule

bind weighted_3x3_smoothing_stencil w3ss_checker u_w3ss_checker (.*);

`default_nettype wire
